FILE: rtl/core/cossim_pkg.sv
// ----------------------------------------------------------------------------
// cossim_pkg
// Shared widths and defaults for the cosine similarity scoring block.
// ----------------------------------------------------------------------------
package cossim_pkg;

    localparam int DEF_MAX_DIM      = 4096;
    localparam int DEF_ELEMENT_BITS = 16;

    // Port field widths.
    localparam int FIELD_BITS = 16;
    localparam int SCORE_BITS = 16;
    localparam int LEN_BITS   = 13;

    // Accumulator widths; the sums wrap at these widths.
    localparam int DOT_BITS  = 44;
    localparam int NORM_BITS = 43;

    // Widest element the block can be built for.
    localparam int ELEM_MAX_BITS = 32;

    // Shared multiplier: one 32-bit limb per operand, plus a sign bit.
    localparam int LIMB_BITS = 32;
    localparam int MUL_BITS  = LIMB_BITS + 1;
    localparam int ACC_BITS  = 4 * LIMB_BITS;

    // Score^2 times the norm product is compared with dot^2 scaled by 2^30.
    localparam int RHS_SHIFT = 2 * (SCORE_BITS - 1);

endpackage

FILE: rtl/core/cosine_similarity_score.sv
// ----------------------------------------------------------------------------
// cosine_similarity_score
// Streaming cosine similarity of two fixed-point vectors, Q1.15 result.
// ----------------------------------------------------------------------------
// Usage:
//   Element pairs arrive on the input channel (i_in_valid / o_in_ready), one
//   request per pair, with i_last_element marking the final pair. The block
//   accumulates q*s, q*q and s*s through one shared 33x33 multiplier, so each
//   request runs S_ACC_QS, S_ACC_QQ, S_ACC_SS until o_in_ready returns.
//   On the last pair the block runs a square-root/divide search: the squared
//   dot product and the norm product are formed limb by limb on the same
//   multiplier, then 16 score bits are decided one per trial. Length errors
//   and zero norms are reported from S_CHECK, without the search.
//   Results leave on o_out_valid / i_out_ready through an output register, so
//   new pairs are taken while a result waits; if the receiver stalls and a
//   second result is ready, the block holds in S_CHECK or S_FINAL until the
//   register frees up.
//   i_cfg_we writes expected_length at any cycle; it should only change while
//   the block is idle. Synchronous reset clears the accumulators, the
//   configured length and the output valid flag.
// ----------------------------------------------------------------------------
module cosine_similarity_score
    import cossim_pkg::*;
#(
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic        [LEN_BITS-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [FIELD_BITS-1:0] i_query_element,
    input  logic signed [FIELD_BITS-1:0] i_stored_element,
    input  logic                         i_last_element,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SCORE_BITS-1:0] o_score,
    output logic                         o_zero_vector,
    output logic                         o_length_error
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (CNT_W > LEN_BITS) ? CNT_W : LEN_BITS;
    localparam int BIT_W = $clog2(SCORE_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_QS,
        S_ACC_QQ,
        S_ACC_SS,
        S_CHECK,
        S_TRY,
        S_MUL,
        S_CMP,
        S_FINAL
    } t_state;

    typedef enum logic [1:0] {
        PH_DSQ,
        PH_PROD,
        PH_SQ,
        PH_LHS
    } t_phase;

    t_state                   r_state;
    t_phase                   r_phase;
    logic [ELEMENT_BITS-1:0]  r_q;
    logic [ELEMENT_BITS-1:0]  r_s;
    logic                     r_last;
    logic                     r_skip;
    logic [DOT_BITS-1:0]      r_dot;
    logic [NORM_BITS-1:0]     r_nq;
    logic [NORM_BITS-1:0]     r_ns;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic [LEN_BITS-1:0]      r_exp;
    logic [2*LIMB_BITS-1:0]   r_opa;
    logic [3*LIMB_BITS-1:0]   r_opb;
    logic                     r_two_a;
    logic [1:0]               r_nb_last;
    logic                     r_ia;
    logic [1:0]               r_jb;
    logic [ACC_BITS-1:0]      r_acc;
    logic [ACC_BITS-1:0]      r_rhs;
    logic [3*LIMB_BITS-1:0]   r_prod;
    logic [SCORE_BITS-1:0]    r_m;
    logic [BIT_W-1:0]         r_bit;
    logic                     r_neg;
    logic                     r_out_valid;
    logic [SCORE_BITS-1:0]    r_score;
    logic                     r_zero;
    logic                     r_lerr;

    logic [ELEM_MAX_BITS-1:0]   q_wide;
    logic [ELEM_MAX_BITS-1:0]   s_wide;
    logic signed [MUL_BITS-1:0] q_ext;
    logic signed [MUL_BITS-1:0] s_ext;
    logic [LIMB_BITS-1:0]       limb_a;
    logic [LIMB_BITS-1:0]       limb_b;
    logic signed [MUL_BITS-1:0] mul_a;
    logic signed [MUL_BITS-1:0] mul_b;
    logic signed [2*MUL_BITS-1:0] mul_p;
    logic [ACC_BITS-1:0]        prod_u;
    logic [ACC_BITS-1:0]        prod_sh;
    logic [1:0]                 limb_pos;
    logic [ACC_BITS-1:0]        n_acc;
    logic                       mul_done;
    logic [DOT_BITS-1:0]        dot_mag;
    logic [SCORE_BITS-1:0]      trial;
    logic                       len_err;
    logic                       zero_norm;
    logic [SCORE_BITS-1:0]      lim;
    logic [SCORE_BITS-1:0]      clamped;
    logic [SCORE_BITS-1:0]      score_val;
    logic                       out_free;
    logic                       res_load;

    // Elements are the low ELEMENT_BITS of the zero-extended field.
    assign q_wide = ELEM_MAX_BITS'(unsigned'(i_query_element));
    assign s_wide = ELEM_MAX_BITS'(unsigned'(i_stored_element));
    assign q_ext  = signed'({{(MUL_BITS-ELEMENT_BITS){r_q[ELEMENT_BITS-1]}}, r_q});
    assign s_ext  = signed'({{(MUL_BITS-ELEMENT_BITS){r_s[ELEMENT_BITS-1]}}, r_s});

    assign limb_a = r_ia ? r_opa[2*LIMB_BITS-1:LIMB_BITS] : r_opa[LIMB_BITS-1:0];

    always_comb begin
        case (r_jb)
            2'd0:    limb_b = r_opb[LIMB_BITS-1:0];
            2'd1:    limb_b = r_opb[2*LIMB_BITS-1:LIMB_BITS];
            2'd2:    limb_b = r_opb[3*LIMB_BITS-1:2*LIMB_BITS];
            default: limb_b = '0;
        endcase
    end

    always_comb begin
        case (r_state)
            S_ACC_QS: begin
                mul_a = q_ext;
                mul_b = s_ext;
            end
            S_ACC_QQ: begin
                mul_a = q_ext;
                mul_b = q_ext;
            end
            S_ACC_SS: begin
                mul_a = s_ext;
                mul_b = s_ext;
            end
            default: begin
                mul_a = signed'({1'b0, limb_a});
                mul_b = signed'({1'b0, limb_b});
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_u   = ACC_BITS'(mul_p[2*LIMB_BITS-1:0]);
    assign limb_pos = {1'b0, r_ia} + r_jb;

    always_comb begin
        case (limb_pos)
            2'd0:    prod_sh = prod_u;
            2'd1:    prod_sh = prod_u << LIMB_BITS;
            2'd2:    prod_sh = prod_u << (2 * LIMB_BITS);
            default: prod_sh = prod_u << (3 * LIMB_BITS);
        endcase
    end

    assign n_acc    = r_acc + prod_sh;
    assign mul_done = (r_ia == r_two_a) && (r_jb == r_nb_last);

    assign dot_mag = r_dot[DOT_BITS-1] ? (DOT_BITS'(0) - r_dot) : r_dot;
    assign trial   = r_m | (SCORE_BITS'(1) << r_bit);

    assign len_err   = r_ovf || ((r_exp != '0) &&
                       (CMP_W'(r_cnt) != CMP_W'(r_exp)));
    assign zero_norm = (r_nq == '0) || (r_ns == '0);

    // Positive scores saturate one step below the negative limit.
    assign lim       = r_neg ? (SCORE_BITS'(1) << (SCORE_BITS - 1))
                             : ((SCORE_BITS'(1) << (SCORE_BITS - 1)) - SCORE_BITS'(1));
    assign clamped   = r_m > lim ? lim : r_m;
    assign score_val = r_neg ? (SCORE_BITS'(0) - clamped) : clamped;
    assign out_free  = !r_out_valid || i_out_ready;
    assign res_load  = out_free && (((r_state == S_CHECK) && (len_err || zero_norm)) ||
                                    (r_state == S_FINAL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_DSQ;
            r_dot       <= '0;
            r_nq        <= '0;
            r_ns        <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_skip      <= 1'b0;
            r_exp       <= '0;
            r_out_valid <= 1'b0;
            r_ia        <= 1'b0;
            r_jb        <= '0;
            r_two_a     <= 1'b0;
            r_nb_last   <= '0;
            r_bit       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_exp <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && !res_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_q    <= q_wide[ELEMENT_BITS-1:0];
                        r_s    <= s_wide[ELEMENT_BITS-1:0];
                        r_last <= i_last_element;
                        if (r_cnt >= CNT_W'(MAX_DIM)) begin
                            r_skip <= 1'b1;
                            r_ovf  <= 1'b1;
                        end else begin
                            r_skip <= 1'b0;
                            r_cnt  <= r_cnt + CNT_W'(1);
                        end
                        r_state <= S_ACC_QS;
                    end
                end
                S_ACC_QS: begin
                    if (!r_skip) begin
                        r_dot <= r_dot + mul_p[DOT_BITS-1:0];
                    end
                    r_state <= S_ACC_QQ;
                end
                S_ACC_QQ: begin
                    if (!r_skip) begin
                        r_nq <= r_nq + mul_p[NORM_BITS-1:0];
                    end
                    r_state <= S_ACC_SS;
                end
                S_ACC_SS: begin
                    if (!r_skip) begin
                        r_ns <= r_ns + mul_p[NORM_BITS-1:0];
                    end
                    r_state <= r_last ? S_CHECK : S_IDLE;
                end
                S_CHECK: begin
                    if (len_err || zero_norm) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_score     <= '0;
                            r_lerr      <= len_err;
                            r_zero      <= !len_err;
                            r_dot       <= '0;
                            r_nq        <= '0;
                            r_ns        <= '0;
                            r_cnt       <= '0;
                            r_ovf       <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_neg     <= r_dot[DOT_BITS-1];
                        r_opa     <= (2*LIMB_BITS)'(dot_mag);
                        r_opb     <= (3*LIMB_BITS)'(dot_mag);
                        r_two_a   <= 1'b1;
                        r_nb_last <= 2'd1;
                        r_ia      <= 1'b0;
                        r_jb      <= '0;
                        r_acc     <= '0;
                        r_phase   <= PH_DSQ;
                        r_state   <= S_MUL;
                    end
                end
                S_TRY: begin
                    r_opa     <= (2*LIMB_BITS)'(trial);
                    r_opb     <= (3*LIMB_BITS)'(trial);
                    r_two_a   <= 1'b0;
                    r_nb_last <= '0;
                    r_ia      <= 1'b0;
                    r_jb      <= '0;
                    r_acc     <= '0;
                    r_phase   <= PH_SQ;
                    r_state   <= S_MUL;
                end
                S_MUL: begin
                    if (!mul_done) begin
                        r_acc <= n_acc;
                        if (r_jb == r_nb_last) begin
                            r_jb <= '0;
                            r_ia <= 1'b1;
                        end else begin
                            r_jb <= r_jb + 2'd1;
                        end
                    end else begin
                        // Each finished product sets up the next product or step.
                        case (r_phase)
                            PH_DSQ: begin
                                r_rhs     <= n_acc << RHS_SHIFT;
                                r_opa     <= (2*LIMB_BITS)'(r_nq);
                                r_opb     <= (3*LIMB_BITS)'(r_ns);
                                r_two_a   <= 1'b1;
                                r_nb_last <= 2'd1;
                                r_ia      <= 1'b0;
                                r_jb      <= '0;
                                r_acc     <= '0;
                                r_phase   <= PH_PROD;
                            end
                            PH_PROD: begin
                                r_prod  <= n_acc[3*LIMB_BITS-1:0];
                                r_m     <= '0;
                                r_bit   <= BIT_W'(SCORE_BITS - 1);
                                r_state <= S_TRY;
                            end
                            PH_SQ: begin
                                r_opa     <= (2*LIMB_BITS)'(n_acc[LIMB_BITS-1:0]);
                                r_opb     <= r_prod;
                                r_two_a   <= 1'b0;
                                r_nb_last <= 2'd2;
                                r_ia      <= 1'b0;
                                r_jb      <= '0;
                                r_acc     <= '0;
                                r_phase   <= PH_LHS;
                            end
                            default: begin
                                r_acc   <= n_acc;
                                r_state <= S_CMP;
                            end
                        endcase
                    end
                end
                S_CMP: begin
                    if (r_acc <= r_rhs) begin
                        r_m <= trial;
                    end
                    if (r_bit == '0) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_bit   <= r_bit - BIT_W'(1);
                        r_state <= S_TRY;
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_score     <= score_val;
                        r_lerr      <= 1'b0;
                        r_zero      <= 1'b0;
                        r_dot       <= '0;
                        r_nq        <= '0;
                        r_ns        <= '0;
                        r_cnt       <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_score        = signed'(r_score);
    assign o_zero_vector  = r_zero;
    assign o_length_error = r_lerr;

endmodule

FILE: rtl/core/cossim_chk.sv
// ----------------------------------------------------------------------------
// cossim_chk
// Port-level checks for the cosine similarity scoring block.
// ----------------------------------------------------------------------------
module cossim_chk
    import cossim_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [SCORE_BITS-1:0] o_score,
    input logic                         o_zero_vector,
    input logic                         o_length_error
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_score) &&
        $stable(o_zero_vector) && $stable(o_length_error))
        else $error("result changed while stalled");

    // A length error masks the zero flag and forces a zero score.
    a_len_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_error |-> (o_score == '0) && !o_zero_vector)
        else $error("length error with nonzero score or zero flag");

    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_vector |-> (o_score == '0))
        else $error("zero vector with nonzero score");

    // Every request occupies the shared multiplier, so o_in_ready drops once it is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken on back-to-back cycles");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind cosine_similarity_score cossim_chk u_cossim_chk (.*);
